// ----- rtl/pfa_pkg.sv -----
// shared types and constants for the page frame allocator
package pfa_pkg;

  localparam int RANGE_DEPTH_DEF = 64;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int PAGE_SHIFT = 12;
  localparam int PN_W       = 52;
  localparam int ADDR_W     = 64;

  localparam logic [ADDR_W-1:0] FLOOR_RESET = 64'h0000_0000_0010_0000;
  localparam logic [PN_W-1:0]   PN_MAX      = {PN_W{1'b1}};

  localparam logic [2:0] K_CLEAR  = 3'd0;
  localparam logic [2:0] K_ADD    = 3'd1;
  localparam logic [2:0] K_FINISH = 3'd2;
  localparam logic [2:0] K_ALLOC  = 3'd3;
  localparam logic [2:0] K_FREE   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [2:0]      kind;
    logic            region_ok;
    logic [PN_W-1:0] start_page;
    logic [PN_W-1:0] count;
    logic            free_ok;
    logic [PN_W-1:0] ret_pn;
  } pfa_cmd_t;

endpackage

// ----- rtl/pfa_front.sv -----
// front end: decodes words, clips regions, and queues commands for the back end
module pfa_front
  import pfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] floor_addr,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_kind,
  input  logic [ADDR_W-1:0] region_base,
  input  logic [ADDR_W-1:0] region_size,
  input  logic              region_usable,
  input  logic [ADDR_W-1:0] free_addr,
  output logic              cmd_valid,
  output pfa_cmd_t          cmd,
  input  logic              cmd_pop
);

  pfa_cmd_t        q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      used;
  pfa_cmd_t        dec;

  logic [ADDR_W:0]   sum;
  logic [PN_W-1:0]   start_pg;
  logic [PN_W-1:0]   end_pg;
  logic [PN_W-1:0]   flr_pg;
  logic [PN_W-1:0]   clip_pg;
  logic              base_bad;
  logic              floor_bad;

  always_comb begin
    sum       = {1'b0, region_base} + {1'b0, region_size};
    base_bad  = (&region_base[ADDR_W-1:PAGE_SHIFT]) && (|region_base[PAGE_SHIFT-1:0]);
    floor_bad = (&floor_addr[ADDR_W-1:PAGE_SHIFT]) && (|floor_addr[PAGE_SHIFT-1:0]);
    start_pg  = region_base[ADDR_W-1:PAGE_SHIFT]
                + PN_W'(|region_base[PAGE_SHIFT-1:0]);
    end_pg    = sum[ADDR_W] ? PN_MAX : sum[ADDR_W-1:PAGE_SHIFT];
    flr_pg    = floor_addr[ADDR_W-1:PAGE_SHIFT] + PN_W'(|floor_addr[PAGE_SHIFT-1:0]);
    clip_pg   = (start_pg < flr_pg) ? flr_pg : start_pg;

    dec.kind       = in_kind;
    dec.region_ok  = region_usable && (region_size[ADDR_W-1:PAGE_SHIFT] != '0)
                     && !base_bad && !floor_bad && (end_pg > start_pg)
                     && (end_pg > flr_pg) && (end_pg > clip_pg);
    dec.start_page = clip_pg;
    dec.count      = end_pg - clip_pg;
    dec.free_ok    = (free_addr != '0) && (free_addr[PAGE_SHIFT-1:0] == '0);
    dec.ret_pn     = free_addr[ADDR_W-1:PAGE_SHIFT];
  end

  assign in_ready  = (used != 2'd2);
  assign cmd_valid = (used != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      used <= used + 2'(in_valid && in_ready) - 2'(cmd_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid) else $error("pop from empty command queue");
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= 2'd2) else $error("command queue overfilled");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (used == 2'd2) && !cmd_pop |=> (used == 2'd2)) else $error("full queue lost entry");
`endif

endmodule

// ----- rtl/pfa_back.sv -----
// back end: range table, recycle stack, counters and result register
module pfa_back
  import pfa_pkg::*;
#(
  parameter int RANGE_DEPTH = RANGE_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  pfa_cmd_t          cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_page_addr,
  output logic              available,
  output logic [PN_W-1:0]   stat_total,
  output logic [PN_W-1:0]   stat_free
);

  localparam int RFW = $clog2(RANGE_DEPTH + 1);
  localparam int SFW = $clog2(STACK_DEPTH + 1);
  localparam int RIW = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  logic [PN_W-1:0] start_mem [RANGE_DEPTH];
  logic [PN_W-1:0] len_mem   [RANGE_DEPTH];
  logic [PN_W-1:0] stack_mem [STACK_DEPTH];

  logic [1:0]      state;
  logic            init_flag;
  logic            avail_flag;
  logic [PN_W-1:0] total_cnt;
  logic [PN_W-1:0] free_cnt;
  logic [RFW-1:0]  range_fill;
  logic [RFW-1:0]  range_cur;
  logic [PN_W-1:0] page_cur;
  logic [SFW-1:0]  stack_fill;
  logic            use_stack;

  logic [PN_W-1:0] rs_q;
  logic [PN_W-1:0] rl_q;
  logic [PN_W-1:0] sp_q;
  logic [SIW-1:0]  stack_top;
  logic [PN_W:0]   new_total;
  logic            add_ok;
  logic            free_go;
  logic [PN_W-1:0] free_dec;
  logic [PN_W-1:0] bump_pg;

  assign stack_top = SIW'(stack_fill - SFW'(1));
  assign new_total = {1'b0, total_cnt} + {1'b0, cmd.count};
  assign add_ok    = cmd.region_ok && (range_fill < RFW'(RANGE_DEPTH)) && !new_total[PN_W];
  assign free_go   = init_flag && avail_flag && cmd.free_ok
                     && (stack_fill < SFW'(STACK_DEPTH)) && (free_cnt < total_cnt);
  assign free_dec  = (free_cnt != '0) ? free_cnt - PN_W'(1) : free_cnt;
  assign bump_pg   = rs_q + page_cur;

  assign cmd_pop    = (state == S_IDLE) && cmd_valid && !out_valid;
  assign available  = avail_flag;
  assign stat_total = total_cnt;
  assign stat_free  = free_cnt;

  // registered reads follow the live stack top and range cursor
  always_ff @(posedge clk) begin
    rs_q <= start_mem[range_cur[RIW-1:0]];
    rl_q <= len_mem[range_cur[RIW-1:0]];
    sp_q <= stack_mem[stack_top];
    if (cmd_pop && (cmd.kind == K_ADD) && add_ok) begin
      start_mem[range_fill[RIW-1:0]] <= cmd.start_page;
      len_mem[range_fill[RIW-1:0]]   <= cmd.count;
    end
    if (cmd_pop && (cmd.kind == K_FREE) && free_go) begin
      stack_mem[stack_fill[SIW-1:0]] <= cmd.ret_pn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      init_flag  <= 1'b0;
      avail_flag <= 1'b0;
      total_cnt  <= '0;
      free_cnt   <= '0;
      range_fill <= '0;
      range_cur  <= '0;
      page_cur   <= '0;
      stack_fill <= '0;
      use_stack  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            out_page_addr <= '0;
            out_status    <= ST_IGNORED;
            out_valid     <= 1'b1;
            unique case (cmd.kind)
              K_CLEAR: begin
                init_flag  <= 1'b1;
                avail_flag <= 1'b0;
                total_cnt  <= '0;
                free_cnt   <= '0;
                range_fill <= '0;
                range_cur  <= '0;
                page_cur   <= '0;
                stack_fill <= '0;
                out_status <= ST_OK;
              end
              K_ADD: begin
                if (add_ok) begin
                  range_fill <= range_fill + RFW'(1);
                  total_cnt  <= new_total[PN_W-1:0];
                  free_cnt   <= free_cnt + cmd.count;
                  out_status <= ST_OK;
                end
              end
              K_FINISH: begin
                avail_flag <= (total_cnt != '0);
                out_status <= (total_cnt != '0) ? ST_OK : ST_NOMEM;
              end
              K_ALLOC: begin
                if (!init_flag || !avail_flag) begin
                  out_status <= ST_NOMEM;
                end else begin
                  out_valid <= 1'b0;
                  use_stack <= (stack_fill != '0);
                  state     <= S_ALLOC;
                end
              end
              K_FREE: begin
                if (free_go) begin
                  stack_fill <= stack_fill + SFW'(1);
                  free_cnt   <= free_cnt + PN_W'(1);
                  out_status <= ST_OK;
                end
              end
              default: begin
                out_status <= ST_IGNORED;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (use_stack) begin
            stack_fill    <= stack_fill - SFW'(1);
            free_cnt      <= free_dec;
            out_page_addr <= {sp_q, {PAGE_SHIFT{1'b0}}};
            out_status    <= (sp_q != '0) ? ST_OK : ST_NOMEM;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end else if (range_cur < range_fill) begin
            if (page_cur < rl_q) begin
              page_cur      <= page_cur + PN_W'(1);
              free_cnt      <= free_dec;
              out_page_addr <= {bump_pg, {PAGE_SHIFT{1'b0}}};
              out_status    <= (bump_pg != '0) ? ST_OK : ST_NOMEM;
              out_valid     <= 1'b1;
              state         <= S_IDLE;
            end else begin
              // range used up, move on and wait for the table read
              range_cur <= range_cur + RFW'(1);
              page_cur  <= '0;
              state     <= S_WAIT;
            end
          end else begin
            out_page_addr <= '0;
            out_status    <= ST_NOMEM;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_WAIT: begin
          state <= S_ALLOC;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= total_cnt) else $error("free count above total");
  a_addr_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_page_addr != '0) |-> (out_status == ST_OK))
    else $error("page returned without ok status");
  a_busy_no_out: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid) else $error("result shown while busy");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_fill <= SFW'(STACK_DEPTH)) else $error("stack overfilled");
`endif

endmodule

// ----- rtl/page_frame_allocator.sv -----
// top level of the page frame allocator
//
//  channel   dir  handshake                 contents
//  s_axis    in   s_axis_tvalid/tready      tuser kind, tdata region and free fields
//  m_axis    out  m_axis_tvalid/tready      tdata status, page and statistics
//  cfg       in   cfg_we                    floor_addr
//
// a result is registered when its word is popped; an allocate served from
// the stack or the current range is registered in S_ALLOC, and each step of the range
// cursor to the next range passes through S_WAIT (one registered table read per step).
// the next command is popped only after the result is taken. a two-entry command queue
// lets the input keep accepting while a result waits. reset clears all counters and
// flags; table and stack contents are not cleared.
module page_frame_allocator
  import pfa_pkg::*;
#(
  parameter int RANGE_DEPTH = RANGE_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // region_base, region_size, region_usable, free_addr, zero pad
  input  logic [199:0]      s_axis_tdata,
  // kind
  input  logic [2:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status, page_addr, available, total page count, free page count, zero pad
  output logic [175:0]      m_axis_tdata,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  logic [ADDR_W-1:0] floor_addr;
  logic              cmd_valid;
  logic              cmd_pop;
  pfa_cmd_t          cmd;
  logic [1:0]        status;
  logic [ADDR_W-1:0] page_addr;
  logic              available;
  logic [PN_W-1:0]   stat_total;
  logic [PN_W-1:0]   stat_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_addr <= FLOOR_RESET;
    end else if (cfg_we) begin
      floor_addr <= cfg_wdata;
    end
  end

  pfa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .floor_addr   (floor_addr),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_kind      (s_axis_tuser),
    .region_base  (s_axis_tdata[63:0]),
    .region_size  (s_axis_tdata[127:64]),
    .region_usable(s_axis_tdata[128]),
    .free_addr    (s_axis_tdata[192:129]),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  pfa_back #(
    .RANGE_DEPTH(RANGE_DEPTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_status   (status),
    .out_page_addr(page_addr),
    .available    (available),
    .stat_total   (stat_total),
    .stat_free    (stat_free)
  );

  assign m_axis_tdata = {5'd0, stat_free, stat_total, available, page_addr, status};

endmodule
